// ===== rtl/core/dsfs_pkg.sv =====
package dsfs_pkg;

    localparam int SLOTS_DEF          = 7;
    localparam int SETUP_INTERVAL_DEF = 100;

    localparam int STORE_DEPTH = 14;
    localparam int STORE_AW    = 4;
    localparam int CD_W        = 7;
    localparam int CFG_DATA_W  = 6;
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = 1;

    localparam logic [1:0] CFG_MODULE_MODE    = 2'd0;
    localparam logic [1:0] CFG_PROTOCOL_FLAGS = 2'd1;
    localparam logic [1:0] CFG_CHANNEL_COUNT  = 2'd2;

    localparam logic [1:0] MODE_BIND  = 2'd1;
    localparam logic [1:0] MODE_RANGE = 2'd2;

    localparam logic [7:0] SYNC_BYTE   = 8'hAA;
    localparam logic [7:0] BIND_FLAGS  = 8'hC0;
    localparam logic [7:0] POWER_FULL  = 8'd7;
    localparam logic [7:0] POWER_RANGE = 8'd4;
    localparam logic [7:0] MODEL_BYTE  = 8'd1;
    localparam logic [7:0] EMPTY_BYTE  = 8'hFF;

    localparam logic [4:0] BIND_COUNT  = 5'd12;
    localparam logic [4:0] COUNT_RESET = 5'd8;
    localparam int         FLAG_RES11_BIT = 2;

    localparam logic signed [21:0] SCALE11_MUL = 22'sd349;
    localparam logic signed [13:0] SCALE11_MID = 14'sd1024;
    localparam logic signed [13:0] SCALE11_MAX = 14'sd2047;
    localparam logic signed [16:0] SCALE10_MUL = 17'sd13;
    localparam logic signed [12:0] SCALE10_MID = 13'sd512;
    localparam logic signed [12:0] SCALE10_MAX = 13'sd1023;

    typedef logic signed [12:0] t_chan;

    typedef struct packed {
        logic       is_frame;
        logic [3:0] idx;
        t_chan      value;
    } t_cmd;

    // scale a stored channel value into a 16-bit slot word, index on top
    function automatic logic [15:0] slot_word(t_chan v, logic [4:0] c, logic res11);
        logic signed [21:0] p11;
        logic signed [16:0] p10;
        logic signed [13:0] t11;
        logic signed [12:0] t10;
        logic [10:0]        s11;
        logic [9:0]         s10;
        p11 = v * SCALE11_MUL;
        p10 = v * SCALE10_MUL;
        t11 = 14'(p11 >>> 9) + SCALE11_MID;
        t10 = 13'(p10 >>> 5) + SCALE10_MID;
        if (t11 < 0) begin
            s11 = '0;
        end else if (t11 > SCALE11_MAX) begin
            s11 = SCALE11_MAX[10:0];
        end else begin
            s11 = t11[10:0];
        end
        if (t10 < 0) begin
            s10 = '0;
        end else if (t10 > SCALE10_MAX) begin
            s10 = SCALE10_MAX[9:0];
        end else begin
            s10 = t10[9:0];
        end
        return res11 ? {c, s11} : {1'b0, c, s10};
    endfunction

endpackage

// ===== rtl/core/dsfs_if.sv =====
interface dsfs_req_if;
    logic               valid;
    logic               ready;
    logic               req_type;
    logic [3:0]         channel_index;
    logic signed [11:0] channel_value;
    logic signed [9:0]  center_offset;

    modport source (output valid, output req_type, output channel_index,
                    output channel_value, output center_offset, input ready);
    modport sink   (input valid, input req_type, input channel_index,
                    input channel_value, input center_offset, output ready);
endinterface

interface dsfs_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       last_byte;

    modport source (output valid, output out_byte, output last_byte, input ready);
    modport sink   (input valid, input out_byte, input last_byte, output ready);
endinterface

// ===== rtl/core/dsfs_front.sv =====
module dsfs_front import dsfs_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    dsfs_req_if.sink  i_req,
    output logic      o_cmd_valid,
    output t_cmd      o_cmd,
    input  logic      i_cmd_pop
);

    t_cmd                 r_q [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]  r_wr_ptr;
    logic [QUEUE_AW-1:0]  r_rd_ptr;
    logic [QUEUE_AW:0]    r_cnt;
    t_cmd                 n_cmd;
    logic                 keep;
    logic                 push;

    assign i_req.ready = (r_cnt != (QUEUE_AW+1)'(QUEUE_DEPTH));

    // classify: a load beyond the store is taken and dropped here
    always_comb begin
        n_cmd.is_frame = i_req.req_type;
        n_cmd.idx      = i_req.channel_index;
        n_cmd.value    = 13'(i_req.channel_value) + (13'(i_req.center_offset) <<< 1);
        keep = i_req.req_type || (i_req.channel_index < 4'(STORE_DEPTH));
        push = i_req.valid && i_req.ready && keep;
    end

    assign o_cmd_valid = (r_cnt != '0);
    assign o_cmd       = r_q[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_cmd_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_cnt <= r_cnt + (QUEUE_AW+1)'(push) - (QUEUE_AW+1)'(i_cmd_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr_ptr] <= n_cmd;
        end
    end

endmodule

// ===== rtl/core/dsfs_back.sv =====
module dsfs_back import dsfs_pkg::*; #(
    parameter int SLOTS_PER_PACKET = SLOTS_DEF,
    parameter int SETUP_INTERVAL   = SETUP_INTERVAL_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cmd_valid,
    input  t_cmd                  i_cmd,
    output logic                  o_cmd_pop,
    input  logic                  i_cfg_we,
    input  logic [1:0]            i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    dsfs_byte_if.source           o_byte
);

    localparam logic [4:0] POS_PASS   = 5'd1;
    localparam logic [4:0] POS_FLAGS  = 5'd2;
    localparam logic [4:0] POS_POWER  = 5'd3;
    localparam logic [4:0] POS_COUNT  = 5'd4;
    localparam logic [4:0] SETUP_LEN  = 5'd6;
    localparam logic [4:0] DATA_LEN   = 5'(2 + 2 * SLOTS_PER_PACKET);
    localparam logic [4:0] SLOTS_W    = 5'(SLOTS_PER_PACKET);
    localparam logic [CD_W-1:0] CD_RELOAD = CD_W'(SETUP_INTERVAL);

    logic [1:0]       r_mode;
    logic [5:0]       r_flags;
    logic [4:0]       r_count;
    t_chan            r_store [STORE_DEPTH];
    logic             r_busy;
    logic [4:0]       r_pos;
    logic [1:0]       r_pass;
    logic [CD_W-1:0]  r_cd;
    logic [7:0]       r_lo;
    logic             r_out_valid;
    logic [7:0]       r_out_byte;
    logic             r_out_last;

    logic             adv;
    logic             last;
    logic             bind_mode;
    logic [4:0]       rel;
    logic [4:0]       chan;
    logic             slot_ok;
    t_chan            rd;
    logic [15:0]      word;
    logic [7:0]       n_byte;
    logic [7:0]       n_lo;
    logic [4:0]       count_used;
    logic [1:0]       n_pass;
    logic [CD_W-1:0]  n_cd;

    assign bind_mode = (r_mode == MODE_BIND);
    assign adv       = r_busy && (!r_out_valid || o_byte.ready);
    assign o_cmd_pop = i_cmd_valid && !r_busy;
    assign last      = (r_pos == ((r_pass == 2'd0) ? SETUP_LEN : DATA_LEN) - 5'd1);

    assign o_byte.valid     = r_out_valid;
    assign o_byte.out_byte  = r_out_byte;
    assign o_byte.last_byte = r_out_last;

    // slot lookup: second pass starts after the first packet's channels
    always_comb begin
        rel     = r_pos - 5'd2;
        chan    = 5'(rel[4:1]) + ((r_pass == 2'd2) ? SLOTS_W : 5'd0);
        slot_ok = (chan < r_count) && (chan < 5'(STORE_DEPTH));
        rd      = slot_ok ? r_store[chan[STORE_AW-1:0]] : '0;
        word    = slot_word(rd, chan, r_flags[FLAG_RES11_BIT]);
    end

    always_comb begin
        n_lo = r_lo;
        priority if (r_pos == '0) begin
            n_byte = SYNC_BYTE;
        end else if (r_pos == POS_PASS) begin
            n_byte = {6'd0, r_pass};
        end else if (r_pass == 2'd0) begin
            if (r_pos == POS_FLAGS) begin
                n_byte = bind_mode ? BIND_FLAGS : {2'd0, r_flags};
            end else if (r_pos == POS_POWER) begin
                n_byte = (r_mode == MODE_RANGE) ? POWER_RANGE : POWER_FULL;
            end else if (r_pos == POS_COUNT) begin
                n_byte = bind_mode ? {3'd0, BIND_COUNT} : {3'd0, r_count};
            end else begin
                n_byte = MODEL_BYTE;
            end
        end else if (!rel[0]) begin
            n_byte = slot_ok ? word[15:8] : EMPTY_BYTE;
            n_lo   = slot_ok ? word[7:0]  : EMPTY_BYTE;
        end else begin
            n_byte = r_lo;
        end
    end

    // rotate the pass at frame end; force setup on countdown expiry or bind
    always_comb begin
        count_used = (bind_mode && (r_pass == 2'd0)) ? BIND_COUNT : r_count;
        n_pass     = (r_pass <= 2'd1) ? 2'd2 : 2'd1;
        n_cd       = r_cd;
        if (count_used <= SLOTS_W) begin
            n_pass = 2'd1;
        end
        if (bind_mode) begin
            n_pass = 2'd0;
        end else begin
            n_cd = r_cd - 1'b1;
            if (n_cd == '0) begin
                n_pass = 2'd0;
                n_cd   = CD_RELOAD;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= '0;
            r_flags     <= '0;
            r_count     <= COUNT_RESET;
            r_busy      <= 1'b0;
            r_pos       <= '0;
            r_pass      <= '0;
            r_cd        <= CD_RELOAD;
            r_out_valid <= 1'b0;
            for (int i = 0; i < STORE_DEPTH; i++) begin
                r_store[i] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_MODULE_MODE:    r_mode  <= i_cfg_data[1:0];
                    CFG_PROTOCOL_FLAGS: r_flags <= i_cfg_data[5:0];
                    CFG_CHANNEL_COUNT:  r_count <= i_cfg_data[4:0];
                    default: ;
                endcase
            end
            if (o_cmd_pop) begin
                if (i_cmd.is_frame) begin
                    r_busy <= 1'b1;
                    r_pos  <= '0;
                end else begin
                    r_store[i_cmd.idx[STORE_AW-1:0]] <= i_cmd.value;
                end
            end
            if (adv) begin
                r_out_valid <= 1'b1;
                r_pos       <= r_pos + 5'd1;
                if (last) begin
                    r_busy <= 1'b0;
                    r_pass <= n_pass;
                    r_cd   <= n_cd;
                end
            end else if (o_byte.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out_byte <= n_byte;
            r_out_last <= last;
            r_lo       <= n_lo;
        end
    end

endmodule

// ===== rtl/core/dsmp_serial_frame_sequencer_core.sv =====
// Serial radio-control frame sequencer.
// i_req carries words: a load word (req_type 0) stores channel_value plus
// twice center_offset in the channel store; a tick word (req_type 1)
// builds one frame. o_byte returns the frame one byte per word, with
// last_byte set on its final byte. Loads make no output.
// The i_cfg_* port writes mode, setup flags and channel count; the user
// must do so only while idle; the block itself does not enforce it. With
// the back end idle, a taken tick is queued, popped into the back end, and
// its first byte registered onto o_byte. A setup frame is 6 bytes, a data
// frame 2 + 2*SLOTS_PER_PACKET bytes; the back end sends one byte per cycle
// unless o_byte stalls. The back end runs one word at a time; a two-deep
// queue in front of it lets i_req keep taking words while a frame is still
// going out. When o_byte is stalled the byte holds in the output register
// and the frame pauses; once the queue fills, i_req drops ready.
// Reset clears the store to zero, the pass to setup, the setup countdown
// to SETUP_INTERVAL, and the registers to normal mode, flags 0, 8 channels.
module dsmp_serial_frame_sequencer_core import dsfs_pkg::*; #(
    parameter int SLOTS_PER_PACKET = SLOTS_DEF,
    parameter int SETUP_INTERVAL   = SETUP_INTERVAL_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    dsfs_req_if.sink              i_req,
    dsfs_byte_if.source           o_byte,
    input  logic                  i_cfg_we,
    input  logic [1:0]            i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic cmd_valid;
    t_cmd cmd;
    logic cmd_pop;

    dsfs_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (i_req),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd),
        .i_cmd_pop   (cmd_pop)
    );

    dsfs_back #(
        .SLOTS_PER_PACKET (SLOTS_PER_PACKET),
        .SETUP_INTERVAL   (SETUP_INTERVAL)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_cmd_pop   (cmd_pop),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .o_byte      (o_byte)
    );

endmodule

// ===== rtl/core/dsfs_checker.sv =====
module dsfs_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [7:0] i_out_byte,
    input logic       i_out_last
);

    logic r_start;
    logic r_second;
    logic out_acc;

    assign out_acc = i_out_valid && i_out_ready;

    // track frame boundaries from the output words
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start  <= 1'b1;
            r_second <= 1'b0;
        end else if (out_acc) begin
            r_start  <= i_out_last;
            r_second <= r_start;
        end
    end

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_byte)
            && $stable(i_out_last))
        else $error("output word changed while stalled");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid right after reset");

    a_sync_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_acc && r_start |-> i_out_byte == 8'hAA && !i_out_last)
        else $error("frame does not open with the sync byte");

    a_pass_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_acc && r_second |-> i_out_byte <= 8'd2 && !i_out_last)
        else $error("pass byte out of range");

endmodule

bind dsmp_serial_frame_sequencer_core dsfs_checker u_dsfs_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_byte.valid),
    .i_out_ready (o_byte.ready),
    .i_out_byte  (o_byte.out_byte),
    .i_out_last  (o_byte.last_byte)
);

// ===== test/dsmp_serial_frame_sequencer_core_tb.sv =====
`timescale 1ns / 100ps

module dsmp_serial_frame_sequencer_core_tb;
    import dsfs_pkg::*;

    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int SETTLE_CYCLES   = 8;
    localparam int LONG_HOLD       = 400;
    localparam int NUM_PHASES      = 8;
    localparam int WORDS_PER_PHASE = 55;
    localparam int PRESSURE_PHASE  = 2;
    localparam int CALM_PHASE      = 1;
    localparam int IDLE_PCT        = 18;
    localparam int MAX_REPORTS     = 100;
    localparam int NUM_ROWS        = 27;

    localparam logic       REQ_LOAD    = 1'b0;
    localparam logic       REQ_TICK    = 1'b1;
    localparam logic [1:0] MODE_NORMAL = 2'd0;
    localparam logic [1:0] MODE_SPARE  = 2'd3;

    typedef enum logic [1:0] {ROW_LOAD, ROW_TICK, ROW_CFG} t_row_kind;

    typedef struct packed {
        t_row_kind    kind;
        logic [1:0]   reg_sel;
        logic [3:0]   idx;
        logic [11:0]  val;
        logic [9:0]   ofs;
        logic [4:0]   n_exp;
        logic [127:0] exp_bytes;
    } t_dir_row;

    typedef struct packed {
        logic [7:0] data;
        logic       is_last;
    } t_owed_byte;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  cfg_we;
    logic [1:0]            cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;

    dsfs_req_if  req_if ();
    dsfs_byte_if byte_if ();

    dsmp_serial_frame_sequencer_core dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (req_if),
        .o_byte     (byte_if),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Expected byte values are typed in only where they read off at a glance.
    t_dir_row directed_rows [NUM_ROWS] = '{
        '{ROW_TICK, '0, 4'd0,  12'h000, 10'h000, 5'd6,  128'hAA0000070801},
        '{ROW_LOAD, '0, 4'd0,  12'h7FF, 10'h1FF, 5'd0,  '0},  // both maxima
        '{ROW_LOAD, '0, 4'd1,  12'h800, 10'h200, 5'd0,  '0},  // both minima
        '{ROW_LOAD, '0, 4'd15, 12'h555, 10'h2AA, 5'd0,  '0},  // out of range, dropped
        '{ROW_LOAD, '0, 4'd14, 12'hAAA, 10'h155, 5'd0,  '0},  // out of range, dropped
        '{ROW_TICK, '0, 4'd0,  12'h000, 10'h000, 5'd16,
          128'hAA021E00FFFFFFFFFFFFFFFFFFFFFFFF},
        '{ROW_TICK, '0, 4'd0,  12'h000, 10'h000, 5'd16,
          128'hAA0103FF04000A000E00120016001A00},
        '{ROW_LOAD, '0, 4'd13, 12'h3E8, 10'h12C, 5'd0,  '0},
        '{ROW_LOAD, '0, 4'd7,  12'hFFF, 10'h3FF, 5'd0,  '0},
        '{ROW_CFG,  CFG_PROTOCOL_FLAGS, 4'd0, 12'd63, 10'h000, 5'd0, '0},
        '{ROW_CFG,  CFG_CHANNEL_COUNT,  4'd0, 12'd16, 10'h000, 5'd0, '0},
        '{ROW_TICK, '0, 4'hF,  12'hFFF, 10'h3FF, 5'd0,  '0},
        '{ROW_TICK, '0, 4'd0,  12'h000, 10'h000, 5'd0,  '0},
        '{ROW_CFG,  CFG_MODULE_MODE, 4'd0, 12'(MODE_BIND), 10'h000, 5'd0, '0},
        '{ROW_TICK, '0, 4'd0,  12'h000, 10'h000, 5'd0,  '0},
        '{ROW_TICK, '0, 4'd0,  12'h000, 10'h000, 5'd6,  128'hAA00C0070C01},
        '{ROW_CFG,  CFG_MODULE_MODE, 4'd0, 12'(MODE_RANGE), 10'h000, 5'd0, '0},
        '{ROW_TICK, '0, 4'd0,  12'h000, 10'h000, 5'd6,  128'hAA003F041001},
        '{ROW_CFG,  CFG_MODULE_MODE, 4'd0, 12'(MODE_SPARE), 10'h000, 5'd0, '0},
        '{ROW_CFG,  CFG_PROTOCOL_FLAGS, 4'd0, 12'd0, 10'h000, 5'd0, '0},
        '{ROW_TICK, '0, 4'd0,  12'h000, 10'h000, 5'd0,  '0},
        '{ROW_CFG,  CFG_CHANNEL_COUNT,  4'd0, 12'd0, 10'h000, 5'd0, '0},
        '{ROW_TICK, '0, 4'd0,  12'h000, 10'h000, 5'd16,
          128'hAA01FFFFFFFFFFFFFFFFFFFFFFFFFFFF},
        '{ROW_CFG,  CFG_CHANNEL_COUNT,  4'd0, 12'd7, 10'h000, 5'd0, '0},
        '{ROW_LOAD, '0, 4'd6,  12'h123, 10'h0AB, 5'd0,  '0},
        '{ROW_TICK, '0, 4'd0,  12'h000, 10'h000, 5'd0,  '0},
        '{ROW_TICK, '0, 4'd0,  12'h000, 10'h000, 5'd0,  '0}
    };

    // frame model state
    t_chan           chan_model [STORE_DEPTH];
    logic [1:0]      pass_no;
    logic [CD_W-1:0] setup_cd;
    logic [1:0]      mode_reg;
    logic [5:0]      flags_reg;
    logic [4:0]      count_reg;

    logic [7:0]   frame_bytes [$];
    t_owed_byte   owed_bytes [$];
    int           typed_n;
    logic [127:0] typed_bytes;
    int           mismatch_cnt = 0;
    int           stuck_cycles = 0;
    bit           no_idle = 1'b0;
    bit           hold_trig = 1'b0;

    // Build the bytes of the next frame and advance pass and countdown.
    function automatic void predict_frame();
        int         cnt;
        int         c;
        int         v;
        int         s;
        logic [15:0] w;
        logic [7:0] flag_byte;
        cnt       = count_reg;
        flag_byte = {2'b00, flags_reg};
        frame_bytes.delete();
        frame_bytes.push_back(SYNC_BYTE);
        frame_bytes.push_back({6'd0, pass_no});
        if (pass_no == 2'd0) begin
            if (mode_reg == MODE_BIND) begin
                flag_byte = BIND_FLAGS;
                cnt       = BIND_COUNT;
            end
            frame_bytes.push_back(flag_byte);
            frame_bytes.push_back(mode_reg == MODE_RANGE ? POWER_RANGE : POWER_FULL);
            frame_bytes.push_back(8'(cnt));
            frame_bytes.push_back(MODEL_BYTE);
            pass_no = 2'd1;
        end else begin
            c = (pass_no == 2'd2) ? SLOTS_DEF : 0;
            for (int k = 0; k < SLOTS_DEF; k++) begin
                if (c < cnt && c < STORE_DEPTH) begin
                    v = chan_model[c];
                    if (flags_reg[FLAG_RES11_BIT]) begin
                        s = ((v * int'(SCALE11_MUL)) >>> 9) + int'(SCALE11_MID);
                        s = (s < 0) ? 0 : (s > int'(SCALE11_MAX)) ? int'(SCALE11_MAX) : s;
                        w = 16'(s) | 16'(c << 11);
                    end else begin
                        s = ((v * int'(SCALE10_MUL)) >>> 5) + int'(SCALE10_MID);
                        s = (s < 0) ? 0 : (s > int'(SCALE10_MAX)) ? int'(SCALE10_MAX) : s;
                        w = 16'(s) | 16'(c << 10);
                    end
                    frame_bytes.push_back(w[15:8]);
                    frame_bytes.push_back(w[7:0]);
                end else begin
                    frame_bytes.push_back(EMPTY_BYTE);
                    frame_bytes.push_back(EMPTY_BYTE);
                end
                c++;
            end
        end
        pass_no = (pass_no >= 2'd2) ? 2'd1 : pass_no + 2'd1;
        if (cnt <= SLOTS_DEF) begin
            pass_no = 2'd1;
        end
        if (mode_reg == MODE_BIND) begin
            pass_no = 2'd0;
        end else begin
            setup_cd = setup_cd - 1'b1;
            if (setup_cd == '0) begin
                pass_no  = 2'd0;
                setup_cd = CD_W'(SETUP_INTERVAL_DEF);
            end
        end
    endfunction

    // Bias toward the extremes of a signed field of width w.
    function automatic logic [11:0] pick_signed(int w);
        logic [11:0] r;
        r = 12'($urandom);
        case ($urandom_range(7))
            0: r = 12'(1 << (w - 1));
            1: r = 12'((1 << (w - 1)) - 1);
            default: ;
        endcase
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_owed_byte want;
        if (!i_rst_n) begin
            foreach (chan_model[i]) begin
                chan_model[i] = '0;
            end
            pass_no   = 2'd0;
            setup_cd  = CD_W'(SETUP_INTERVAL_DEF);
            mode_reg  = MODE_NORMAL;
            flags_reg = '0;
            count_reg = COUNT_RESET;
        end else begin
            if (cfg_we) begin
                case (cfg_idx)
                    CFG_MODULE_MODE:    mode_reg  = cfg_data[1:0];
                    CFG_PROTOCOL_FLAGS: flags_reg = cfg_data[5:0];
                    CFG_CHANNEL_COUNT:  count_reg = cfg_data[4:0];
                    default: ;
                endcase
            end
            if (req_if.valid && req_if.ready) begin
                if (req_if.req_type == REQ_LOAD) begin
                    if (req_if.channel_index < STORE_DEPTH) begin
                        chan_model[req_if.channel_index] = t_chan'(int'(req_if.channel_value)
                            + 2 * int'(req_if.center_offset));
                    end
                end else begin
                    predict_frame();
                    if (typed_n != 0) begin
                        frame_bytes.delete();
                        for (int k = 0; k < typed_n; k++) begin
                            frame_bytes.push_back(typed_bytes[8 * (typed_n - 1 - k) +: 8]);
                        end
                    end
                    for (int k = 0; k < frame_bytes.size(); k++) begin
                        owed_bytes.push_back({frame_bytes[k], 1'(k == frame_bytes.size() - 1)});
                    end
                end
            end
            if (byte_if.valid && byte_if.ready) begin
                if (owed_bytes.size() == 0) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= MAX_REPORTS) begin
                        $error("out_byte: expected none, got 0x%02h", byte_if.out_byte);
                    end
                end else begin
                    want = owed_bytes.pop_front();
                    if (byte_if.out_byte !== want.data) begin
                        mismatch_cnt++;
                        if (mismatch_cnt <= MAX_REPORTS) begin
                            $error("out_byte: expected 0x%02h, got 0x%02h", want.data,
                                   byte_if.out_byte);
                        end
                    end
                    if (byte_if.last_byte !== want.is_last) begin
                        mismatch_cnt++;
                        if (mismatch_cnt <= MAX_REPORTS) begin
                            $error("last_byte: expected %0b, got %0b", want.is_last,
                                   byte_if.last_byte);
                        end
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || cfg_we || (req_if.valid && req_if.ready)
                || (byte_if.valid && byte_if.ready)) begin
            stuck_cycles <= 0;
        end else if (stuck_cycles >= WATCHDOG_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
        end
    end

    // Byte sink: random stalls, plus one long hold-off when triggered.
    initial begin
        int hold_left;
        bit hold_seen;
        hold_left     = 0;
        hold_seen     = 1'b0;
        byte_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_seen != hold_trig) begin
                hold_seen = hold_trig;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0) begin
                byte_if.ready <= 1'b0;
                hold_left--;
            end else begin
                byte_if.ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    task automatic send_word(input logic kind, input logic [3:0] idx, input logic [11:0] val,
                             input logic [9:0] ofs, input int n_exp, input logic [127:0] exp_b);
        while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
            req_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        typed_n              = n_exp;
        typed_bytes          = exp_b;
        req_if.valid         <= 1'b1;
        req_if.req_type      <= kind;
        req_if.channel_index <= idx;
        req_if.channel_value <= val;
        req_if.center_offset <= ofs;
        @(posedge i_clk);
        while (!req_if.ready) begin
            @(posedge i_clk);
        end
        @(negedge i_clk);
    endtask

    // Drop valid, wait for every owed byte, then let queued loads finish.
    task automatic settle();
        req_if.valid <= 1'b0;
        while (owed_bytes.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] sel, input logic [CFG_DATA_W-1:0] data);
        cfg_we   <= 1'b1;
        cfg_idx  <= sel;
        cfg_data <= data;
        @(negedge i_clk);
        cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    initial begin
        int         sent;
        logic [3:0] idx;
        logic [1:0] m;
        logic [5:0] f;
        logic [4:0] c;
        i_rst_n              = 1'b0;
        cfg_we               = 1'b0;
        cfg_idx              = CFG_MODULE_MODE;
        cfg_data             = '0;
        req_if.valid         = 1'b0;
        req_if.req_type      = REQ_LOAD;
        req_if.channel_index = '0;
        req_if.channel_value = '0;
        req_if.center_offset = '0;
        typed_n              = 0;
        typed_bytes          = '0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (directed_rows[r]) begin
            if (directed_rows[r].kind == ROW_CFG) begin
                settle();
                write_reg(directed_rows[r].reg_sel, directed_rows[r].val[CFG_DATA_W-1:0]);
            end else begin
                send_word(directed_rows[r].kind == ROW_TICK ? REQ_TICK : REQ_LOAD,
                          directed_rows[r].idx, directed_rows[r].val, directed_rows[r].ofs,
                          directed_rows[r].n_exp, directed_rows[r].exp_bytes);
            end
        end

        for (int p = 0; p < NUM_PHASES; p++) begin
            settle();
            case (p)
                0: begin m = MODE_NORMAL; f = 6'd4;  c = 5'd16; end
                1: begin m = MODE_NORMAL; f = 6'd0;  c = 5'd14; end
                2: begin m = MODE_RANGE;  f = 6'd63; c = 5'd8;  end
                3: begin m = MODE_BIND;   f = 6'd37; c = 5'd3;  end
                4: begin m = MODE_SPARE;  f = 6'd4;  c = 5'd0;  end
                default: begin
                    m = 2'($urandom_range(3));
                    f = 6'($urandom_range(63));
                    c = 5'($urandom_range(16));
                end
            endcase
            write_reg(CFG_MODULE_MODE, CFG_DATA_W'(m));
            write_reg(CFG_PROTOCOL_FLAGS, CFG_DATA_W'(f));
            write_reg(CFG_CHANNEL_COUNT, CFG_DATA_W'(c));
            no_idle = (p == CALM_PHASE);
            // hold the byte side off while words keep coming, so the input backs up
            if (p == PRESSURE_PHASE) begin
                hold_trig = !hold_trig;
            end
            sent = 0;
            while (sent < WORDS_PER_PHASE) begin
                idx = 4'($urandom_range(15));
                if ($urandom_range(9) < 4) begin
                    send_word(REQ_TICK, idx, pick_signed(12), 10'(pick_signed(10)), 0, '0);
                end else begin
                    send_word(REQ_LOAD, idx, pick_signed(12), 10'(pick_signed(10)), 0, '0);
                end
                sent++;
            end
        end
        no_idle = 1'b0;
        settle();

        if (mismatch_cnt == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/dsfs_pkg.sv
rtl/core/dsfs_if.sv
rtl/core/dsfs_front.sv
rtl/core/dsfs_back.sv
rtl/core/dsmp_serial_frame_sequencer_core.sv
rtl/core/dsfs_checker.sv
test/dsmp_serial_frame_sequencer_core_tb.sv
